>>> rtl/leb_pkg.sv
// ----------------------------------------------------------------------------
// leb_pkg
// Shared types and constants of the line edit buffer: key commands,
// controller states, datapath operations and the status word.
// ----------------------------------------------------------------------------
package leb_pkg;

    localparam int unsigned LEB_DEPTH = 128;

    localparam logic [7:0] CHAR_LOW  = 8'd32;
    localparam logic [7:0] CHAR_HIGH = 8'd126;

    typedef enum logic [3:0] {
        CMD_CHAR      = 4'd0,
        CMD_RIGHT     = 4'd1,
        CMD_LEFT      = 4'd2,
        CMD_HOME      = 4'd3,
        CMD_END       = 4'd4,
        CMD_TOGGLE    = 4'd5,
        CMD_BACKSPACE = 4'd6,
        CMD_DELETE    = 4'd7,
        CMD_READ      = 4'd8
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SHIFT,
        ST_PUT,
        ST_TAKE,
        ST_RESPOND
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MOVE,
        OP_DROP,
        OP_PUT_OVR,
        OP_PUT_INS,
        OP_OPEN,
        OP_BACK,
        OP_DEL,
        OP_STEP,
        OP_READ,
        OP_TAKE,
        OP_RESPOND
    } dp_op_t;

    typedef struct packed {
        cmd_t cmd;
        logic printable;
        logic overwrite;
        logic cur_lt_len;
        logic cur_gt_zero;
        logic full;
        logic ridx_in;
        logic shift_done;
    } dp_stat_t;

endpackage

>>> rtl/line_edit_buffer.sv
// ----------------------------------------------------------------------------
// line_edit_buffer
// Single-line text buffer with a cursor, driven by decoded key commands.
// ----------------------------------------------------------------------------
// A transaction is issued by holding command, char_code and read_index with
// start high; it is taken at the rising edge where start is high and busy is
// low. busy stays high until the transaction has been worked off.
// Each transaction gives one result: cursor, length, overwrite_mode,
// read_char and dropped are valid for exactly the one cycle in which done is
// high. The receiver cannot stall; the result is lost if not sampled then.
// Work from acceptance to done: every transaction is loaded, decoded and
// answered. Cursor moves, mode toggle, refused or ignored characters,
// overwrite and append at the end need nothing more; a read adds a step
// that takes the character from the registered RAM output. Insert inside
// the text, backspace and delete first move the tail through the one-read,
// one-write text RAM by one character per cycle; insert then writes the
// new character.
// done rises while busy is already low, so the next transaction can be
// taken in the same cycle as the result.
// Reset empties the buffer: cursor and length zero, insert mode. No clearing
// pass runs; the block can take a transaction as soon as reset is released.
// ----------------------------------------------------------------------------
module line_edit_buffer
    import leb_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = LEB_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [3:0] command,
    input  logic [7:0] char_code,
    input  logic [6:0] read_index,
    output logic       done,
    output logic [7:0] cursor,
    output logic [7:0] length,
    output logic       overwrite_mode,
    output logic [7:0] read_char,
    output logic       dropped
);

    dp_op_t   op;
    dp_stat_t stat;

    leb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .op    (op)
    );

    leb_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .stat           (stat),
        .command        (command),
        .char_code      (char_code),
        .read_index     (read_index),
        .done           (done),
        .cursor         (cursor),
        .length         (length),
        .overwrite_mode (overwrite_mode),
        .read_char      (read_char),
        .dropped        (dropped)
    );

endmodule

>>> rtl/leb_ram.sv
// ----------------------------------------------------------------------------
// leb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module leb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/leb_datapath.sv
// ----------------------------------------------------------------------------
// leb_datapath
// Cursor, length and mode registers, the text RAM with its shift sequencer,
// and the result registers of the line edit buffer.
// ----------------------------------------------------------------------------
module leb_datapath
    import leb_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = LEB_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  dp_op_t     op,
    output dp_stat_t   stat,
    input  logic [3:0] command,
    input  logic [7:0] char_code,
    input  logic [6:0] read_index,
    output logic       done,
    output logic [7:0] cursor,
    output logic [7:0] length,
    output logic       overwrite_mode,
    output logic [7:0] read_char,
    output logic       dropped
);

    localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned AW = $clog2(BUFFER_DEPTH);
    localparam int unsigned RW = (CW > 7) ? CW : 7;

    logic [CW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0] length_reg, length_next;
    logic          ovr_reg, ovr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pend_reg, pend_next;
    logic          done_reg, done_next;

    logic [3:0]    cmd_reg, cmd_next;
    logic [7:0]    char_reg, char_next;
    logic [6:0]    ridx_reg, ridx_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] waddr_reg, waddr_next;
    logic          up_reg, up_next;
    logic [7:0]    rchar_reg, rchar_next;
    logic          drop_reg, drop_next;
    logic [7:0]    cur_out_reg, cur_out_next;
    logic [7:0]    len_out_reg, len_out_next;
    logic          ovr_out_reg, ovr_out_next;
    logic [7:0]    rchar_out_reg, rchar_out_next;
    logic          drop_out_reg, drop_out_next;

    logic          we;
    logic [AW-1:0] wa;
    logic [7:0]    wd;
    logic [AW-1:0] ra;
    logic [7:0]    rdata;
    logic [CW+7:0] cur_wide;
    logic [CW+7:0] len_wide;

    leb_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (wa),
        .wdata (wd),
        .raddr (ra),
        .rdata (rdata)
    );

    assign cur_wide = {8'd0, cursor_reg};
    assign len_wide = {8'd0, length_reg};

    assign stat.cmd         = cmd_t'(cmd_reg);
    assign stat.printable   = (char_reg >= CHAR_LOW) && (char_reg <= CHAR_HIGH);
    assign stat.overwrite   = ovr_reg;
    assign stat.cur_lt_len  = cursor_reg < length_reg;
    assign stat.cur_gt_zero = cursor_reg != '0;
    assign stat.full        = length_reg == CW'(BUFFER_DEPTH);
    assign stat.ridx_in     = RW'(ridx_reg) < RW'(length_reg);
    assign stat.shift_done  = (cnt_reg == '0) && !pend_reg;

    always_comb
    begin
        cursor_next    = cursor_reg;
        length_next    = length_reg;
        ovr_next       = ovr_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        done_next      = 1'b0;
        cmd_next       = cmd_reg;
        char_next      = char_reg;
        ridx_next      = ridx_reg;
        ptr_next       = ptr_reg;
        waddr_next     = waddr_reg;
        up_next        = up_reg;
        rchar_next     = rchar_reg;
        drop_next      = drop_reg;
        cur_out_next   = cur_out_reg;
        len_out_next   = len_out_reg;
        ovr_out_next   = ovr_out_reg;
        rchar_out_next = rchar_out_reg;
        drop_out_next  = drop_out_reg;
        we             = 1'b0;
        wa             = waddr_reg;
        wd             = rdata;
        ra             = ptr_reg;

        unique case (op)
            OP_LOAD:
            begin
                cmd_next   = command;
                char_next  = char_code;
                ridx_next  = read_index;
                rchar_next = 8'd0;
                drop_next  = 1'b0;
            end
            OP_MOVE:
            begin
                case (cmd_t'(cmd_reg))
                    CMD_RIGHT:
                    begin
                        if (cursor_reg < length_reg)
                        begin
                            cursor_next = cursor_reg + 1'b1;
                        end
                    end
                    CMD_LEFT:
                    begin
                        if (cursor_reg != '0)
                        begin
                            cursor_next = cursor_reg - 1'b1;
                        end
                    end
                    CMD_HOME:   cursor_next = '0;
                    CMD_END:    cursor_next = length_reg;
                    CMD_TOGGLE: ovr_next    = ~ovr_reg;
                    default:    cursor_next = cursor_reg;
                endcase
            end
            OP_DROP:
            begin
                drop_next = 1'b1;
            end
            OP_PUT_OVR:
            begin
                we          = 1'b1;
                wa          = AW'(cursor_reg);
                wd          = char_reg;
                cursor_next = cursor_reg + 1'b1;
            end
            OP_PUT_INS:
            begin
                we          = 1'b1;
                wa          = AW'(cursor_reg);
                wd          = char_reg;
                cursor_next = cursor_reg + 1'b1;
                length_next = length_reg + 1'b1;
            end
            OP_OPEN:
            begin
                up_next  = 1'b1;
                ptr_next = AW'(length_reg - 1'b1);
                cnt_next = length_reg - cursor_reg;
            end
            OP_BACK:
            begin
                up_next     = 1'b0;
                ptr_next    = AW'(cursor_reg);
                cnt_next    = length_reg - cursor_reg;
                cursor_next = cursor_reg - 1'b1;
                length_next = length_reg - 1'b1;
            end
            OP_DEL:
            begin
                up_next     = 1'b0;
                ptr_next    = AW'(cursor_reg + 1'b1);
                cnt_next    = length_reg - cursor_reg - 1'b1;
                length_next = length_reg - 1'b1;
            end
            OP_STEP:
            begin
                if (pend_reg)
                begin
                    we = 1'b1;
                end
                if (cnt_reg != '0)
                begin
                    pend_next  = 1'b1;
                    cnt_next   = cnt_reg - 1'b1;
                    waddr_next = up_reg ? ptr_reg + 1'b1 : ptr_reg - 1'b1;
                    ptr_next   = up_reg ? ptr_reg - 1'b1 : ptr_reg + 1'b1;
                end
            end
            OP_READ:
            begin
                ra = AW'(ridx_reg);
            end
            OP_TAKE:
            begin
                rchar_next = rdata;
            end
            OP_RESPOND:
            begin
                done_next      = 1'b1;
                cur_out_next   = cur_wide[7:0];
                len_out_next   = len_wide[7:0];
                ovr_out_next   = ovr_reg;
                rchar_out_next = rchar_reg;
                drop_out_next  = drop_reg;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            length_reg <= '0;
            ovr_reg    <= 1'b0;
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            length_reg <= length_next;
            ovr_reg    <= ovr_next;
            cnt_reg    <= cnt_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        char_reg      <= char_next;
        ridx_reg      <= ridx_next;
        ptr_reg       <= ptr_next;
        waddr_reg     <= waddr_next;
        up_reg        <= up_next;
        rchar_reg     <= rchar_next;
        drop_reg      <= drop_next;
        cur_out_reg   <= cur_out_next;
        len_out_reg   <= len_out_next;
        ovr_out_reg   <= ovr_out_next;
        rchar_out_reg <= rchar_out_next;
        drop_out_reg  <= drop_out_next;
    end

    assign done           = done_reg;
    assign cursor         = cur_out_reg;
    assign length         = len_out_reg;
    assign overwrite_mode = ovr_out_reg;
    assign read_char      = rchar_out_reg;
    assign dropped        = drop_out_reg;

endmodule

>>> rtl/leb_ctrl.sv
// ----------------------------------------------------------------------------
// leb_ctrl
// Controller of the line edit buffer: accepts a key command, sequences
// the datapath through decode, shift, write and read, then responds.
// ----------------------------------------------------------------------------
module leb_ctrl
    import leb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  dp_stat_t stat,
    output dp_op_t   op
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        busy       = state_reg != ST_IDLE;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op         = OP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_RESPOND;
                case (stat.cmd)
                    CMD_CHAR:
                    begin
                        priority if (!stat.printable)
                        begin
                            op = OP_NONE;
                        end
                        else if (stat.overwrite && stat.cur_lt_len)
                        begin
                            op = OP_PUT_OVR;
                        end
                        else if (stat.full)
                        begin
                            op = OP_DROP;
                        end
                        else if (stat.cur_lt_len)
                        begin
                            op         = OP_OPEN;
                            state_next = ST_SHIFT;
                        end
                        else
                        begin
                            op = OP_PUT_INS;
                        end
                    end
                    CMD_RIGHT, CMD_LEFT, CMD_HOME, CMD_END, CMD_TOGGLE:
                    begin
                        op = OP_MOVE;
                    end
                    CMD_BACKSPACE:
                    begin
                        if (stat.cur_gt_zero)
                        begin
                            op         = OP_BACK;
                            state_next = ST_SHIFT;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (stat.cur_lt_len)
                        begin
                            op         = OP_DEL;
                            state_next = ST_SHIFT;
                        end
                    end
                    CMD_READ:
                    begin
                        if (stat.ridx_in)
                        begin
                            op         = OP_READ;
                            state_next = ST_TAKE;
                        end
                    end
                    default:
                    begin
                        op = OP_NONE;
                    end
                endcase
            end
            ST_SHIFT:
            begin
                op = OP_STEP;
                if (stat.shift_done)
                begin
                    state_next = (stat.cmd == CMD_CHAR) ? ST_PUT : ST_RESPOND;
                end
            end
            ST_PUT:
            begin
                op         = OP_PUT_INS;
                state_next = ST_RESPOND;
            end
            ST_TAKE:
            begin
                op         = OP_TAKE;
                state_next = ST_RESPOND;
            end
            ST_RESPOND:
            begin
                op         = OP_RESPOND;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/leb_checker.sv
// ----------------------------------------------------------------------------
// leb_checker
// Port-level checks of the line edit buffer, bound to the top level.
// ----------------------------------------------------------------------------
module leb_checker
    import leb_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = LEB_DEPTH
) (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [3:0] command,
    input logic [7:0] char_code,
    input logic [6:0] read_index,
    input logic       done,
    input logic [7:0] cursor,
    input logic [7:0] length,
    input logic       overwrite_mode,
    input logic [7:0] read_char,
    input logic       dropped
);

    localparam logic [7:0] FULL8 = 8'(BUFFER_DEPTH);
    localparam logic       WRAPS = BUFFER_DEPTH > 255;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while a transaction is in progress");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted transaction did not raise busy");

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !WRAPS) |-> (cursor <= length))
        else $error("cursor beyond text length");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && dropped) |-> (length == FULL8 && read_char == 8'd0))
        else $error("character dropped while buffer not full");

endmodule

bind line_edit_buffer leb_checker #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_leb_checker (.*);
